// ===== rtl/core/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZ77 window decoder package
// Field widths, token kinds and the command word that the control logic
// hands to the output packer.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

   localparam int KIND_W    = 1;
   localparam int LIT_W     = 8;
   localparam int LEN_W     = 9;
   localparam int DIST_W    = 16;
   localparam int DATA_W    = 64;
   localparam int CNT_W     = 4;
   localparam int OCT_W     = 8;
   localparam int OCT_IDX_W = 3;

   localparam logic [KIND_W-1:0] KIND_LITERAL = 1'b0;
   localparam logic [KIND_W-1:0] KIND_MATCH   = 1'b1;

   typedef logic [OCT_W-1:0] octet_type;

   // Command from the control logic to the packer for one cycle.
   typedef struct packed {
      logic      push;      // one copied byte enters the pack register
      logic      flush;     // that byte closes the current output word
      logic      last;      // the closed word is the token's final one
      octet_type octet;     // copied byte, or the literal for a solo word
      logic      solo;      // load a single-word result directly
      logic      solo_bad;  // the solo word flags a bad distance
      logic      solo_lit;  // the solo word carries the literal byte
   } pk_cmd_type;

   // Output register status seen by the control logic.
   typedef struct packed {
      logic free_now;   // the output register can be loaded this cycle
      logic busy_next;  // the output register holds a word next cycle
   } pk_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/lzwd_ifs.sv =====
// ----------------------------------------------------------------------------
// LZ77 window decoder channel interfaces
// Token channel and result channel, both valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwd_req_if;
   import lzwd_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [LIT_W-1:0]    literal_byte;
   logic [LEN_W-1:0]    match_length;
   logic [DIST_W-1:0]   match_distance;

   modport source (
      output valid, kind, literal_byte, match_length, match_distance,
      input  ready
   );
   modport sink (
      input  valid, kind, literal_byte, match_length, match_distance,
      output ready
   );
endinterface

interface lzwd_rsp_if;
   import lzwd_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data_bytes;
   logic [CNT_W-1:0]    byte_count;
   logic                last;
   logic                bad_distance;

   modport source (
      output valid, data_bytes, byte_count, last, bad_distance,
      input  ready
   );
   modport sink (
      input  valid, data_bytes, byte_count, last, bad_distance,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/lzwd_hist_ram.sv =====
// ----------------------------------------------------------------------------
// LZ77 window decoder history memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_hist_ram #(
   parameter int DEPTH = 32768,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire lzwd_pkg::octet_type  wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output lzwd_pkg::octet_type       rd_data
);
   import lzwd_pkg::*;

   octet_type mem [DEPTH];
   octet_type rd_data_ff;

   // A read of the entry written in the same cycle returns the old byte.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lzwd_packer.sv =====
// ----------------------------------------------------------------------------
// LZ77 window decoder output packer
// Collects copied bytes into output words and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_packer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lzwd_pkg::pk_cmd_type cmd,
   output lzwd_pkg::pk_stat_type     stat,
   lzwd_rsp_if.source                rsp_bus
);
   import lzwd_pkg::*;

   logic [DATA_W-1:0]    pack_ff;
   logic [DATA_W-1:0]    pack_in;
   logic [OCT_IDX_W-1:0] pack_cnt_ff;
   logic [OCT_IDX_W-1:0] pack_cnt_in;
   logic [DATA_W-1:0]    merged;

   logic                 out_vld_ff;
   logic                 out_vld_in;
   logic [DATA_W-1:0]    out_data_ff;
   logic [DATA_W-1:0]    out_data_in;
   logic [CNT_W-1:0]     out_cnt_ff;
   logic [CNT_W-1:0]     out_cnt_in;
   logic                 out_last_ff;
   logic                 out_last_in;
   logic                 out_bad_ff;
   logic                 out_bad_in;
   logic                 load;

   assign merged = pack_ff | (DATA_W'(cmd.octet) << {pack_cnt_ff, 3'b000});
   assign load   = (cmd.push && cmd.flush) || cmd.solo;

   always_comb begin
      pack_in     = pack_ff;
      pack_cnt_in = pack_cnt_ff;
      if (cmd.push) begin
         if (cmd.flush) begin
            pack_in     = '0;
            pack_cnt_in = '0;
         end else begin
            pack_in     = merged;
            pack_cnt_in = pack_cnt_ff + OCT_IDX_W'(1);
         end
      end
   end

   always_comb begin
      out_data_in = out_data_ff;
      out_cnt_in  = out_cnt_ff;
      out_last_in = out_last_ff;
      out_bad_in  = out_bad_ff;
      if (cmd.solo) begin
         out_data_in = cmd.solo_lit ? DATA_W'(cmd.octet) : '0;
         out_cnt_in  = cmd.solo_lit ? CNT_W'(1) : '0;
         out_last_in = 1'b1;
         out_bad_in  = cmd.solo_bad;
      end else if (load) begin
         out_data_in = merged;
         out_cnt_in  = CNT_W'(pack_cnt_ff) + CNT_W'(1);
         out_last_in = cmd.last;
         out_bad_in  = 1'b0;
      end
   end

   assign out_vld_in = load || (out_vld_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pack_ff     <= '0;
         pack_cnt_ff <= '0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pack_ff     <= pack_in;
         pack_cnt_ff <= pack_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   assign stat.free_now  = !out_vld_ff || rsp_bus.ready;
   assign stat.busy_next = out_vld_in;

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.data_bytes   = out_data_ff;
   assign rsp_bus.byte_count   = out_cnt_ff;
   assign rsp_bus.last         = out_last_ff;
   assign rsp_bus.bad_distance = out_bad_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lz77_window_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// LZ77 window decoder
// Decodes literal and match tokens against a sliding history window.
// ----------------------------------------------------------------------------
// The unit takes one token at a time. A literal, a match with a bad distance
// (zero or beyond the bytes written so far) and a match of length zero are
// each accepted, then dispatched once the result register is free, and each
// give one result word. A match of length L goes through accept, dispatch,
// one history read per byte, and the write of the last byte. The history
// memory gives one read and one write per cycle, so the copy moves one byte
// per cycle unless a byte is held back, and bytes are packed OUT_BYTES to a
// result word. A byte that closes a word is held back while the result
// register is still holding, or is just being loaded with, the previous
// word. A final word of a single byte is therefore held back behind the
// previous word, and a stalled result side stalls the copy. The history needs
// no clearing after reset; bytes never written are never read because of the
// distance check.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_window_decoder_unit #(
   parameter int WINDOW_SIZE = 32768,
   parameter int MAX_MATCH   = 258,
   parameter int OUT_BYTES   = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   lzwd_req_if.sink   req_bus,
   lzwd_rsp_if.source rsp_bus
);
   import lzwd_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int FW = $clog2(WINDOW_SIZE + 1);
   localparam int LW = $clog2(MAX_MATCH + 1);
   localparam int PW = ((AW > DIST_W) ? AW : DIST_W) + 1;
   localparam int SW = (LW > LEN_W) ? LW : LEN_W;

   localparam logic [AW-1:0]        WP_LAST   = AW'(WINDOW_SIZE - 1);
   localparam logic [FW-1:0]        FILL_MAX  = FW'(WINDOW_SIZE);
   localparam logic [PW-1:0]        WIN_P     = PW'(WINDOW_SIZE);
   localparam logic [SW-1:0]        MAX_S     = SW'(MAX_MATCH);
   localparam logic [OCT_IDX_W-1:0] PACK_LAST = OCT_IDX_W'(OUT_BYTES - 1);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_DISPATCH = 2'd1;
   localparam logic [1:0] ST_COPY     = 2'd2;

   logic [1:0]           state_ff;
   logic [1:0]           state_in;

   logic [KIND_W-1:0]    tok_kind_ff;
   logic [LIT_W-1:0]     tok_lit_ff;
   logic [LEN_W-1:0]     tok_len_ff;
   logic [DIST_W-1:0]    tok_dist_ff;

   logic [AW-1:0]        wp_ff;
   logic [AW-1:0]        wp_in;
   logic [FW-1:0]        fill_ff;
   logic [FW-1:0]        fill_in;

   logic [AW-1:0]        rd_ptr_ff;
   logic [AW-1:0]        rd_ptr_in;
   logic [LW-1:0]        iss_left_ff;
   logic [LW-1:0]        iss_left_in;
   logic [OCT_IDX_W-1:0] iss_cnt_ff;
   logic [OCT_IDX_W-1:0] iss_cnt_in;

   logic                 w_vld_ff;
   logic                 w_flush_ff;
   logic                 w_flush_in;
   logic                 w_last_ff;
   logic                 w_last_in;
   logic                 fwd_ff;
   logic                 fwd_in;
   octet_type            fwd_data_ff;

   logic                 accept;
   logic                 bad_dist;
   logic [SW-1:0]        len_wide;
   logic [LW-1:0]        len_sat;
   logic [PW-1:0]        wp_p;
   logic [PW-1:0]        dist_p;
   logic [PW-1:0]        start_p;
   logic                 completes;
   logic                 issue;
   logic                 lit_wr;
   logic                 wr_en;
   octet_type            wr_data;
   octet_type            rd_data;
   octet_type            w_byte;

   pk_cmd_type           cmd;
   pk_stat_type          stat;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // Token checks made in the dispatch cycle.
   assign bad_dist = (tok_dist_ff == '0) || (PW'(tok_dist_ff) > PW'(fill_ff));
   assign len_wide = (SW'(tok_len_ff) > MAX_S) ? MAX_S : SW'(tok_len_ff);
   assign len_sat  = LW'(len_wide);
   assign wp_p     = PW'(wp_ff);
   assign dist_p   = PW'(tok_dist_ff);
   assign start_p  = (wp_p >= dist_p) ? (wp_p - dist_p) : (wp_p + WIN_P - dist_p);

   // A byte that closes an output word is issued only when the result
   // register will be empty by the time that byte comes back.
   assign completes = (iss_cnt_ff == PACK_LAST) || (iss_left_ff == LW'(1));
   assign issue     = (state_ff == ST_COPY) && (iss_left_ff != '0)
                      && (!completes || !stat.busy_next);

   // The byte read last cycle; when it was read from the entry written in
   // that same cycle, the memory gave the stale byte and the forwarded one
   // is used instead.
   assign w_byte = fwd_ff ? fwd_data_ff : rd_data;

   assign lit_wr  = (state_ff == ST_DISPATCH) && (tok_kind_ff == KIND_LITERAL)
                    && stat.free_now;
   assign wr_en   = w_vld_ff || lit_wr;
   assign wr_data = w_vld_ff ? w_byte : tok_lit_ff;

   assign wp_in   = wr_en ? ((wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1)) : wp_ff;
   assign fill_in = (wr_en && (fill_ff != FILL_MAX)) ? fill_ff + FW'(1) : fill_ff;

   assign fwd_in     = w_vld_ff && (rd_ptr_ff == wp_ff);
   assign w_flush_in = completes;
   assign w_last_in  = (iss_left_ff == LW'(1));

   always_comb begin
      state_in    = state_ff;
      rd_ptr_in   = rd_ptr_ff;
      iss_left_in = iss_left_ff;
      iss_cnt_in  = iss_cnt_ff;
      cmd         = '0;
      cmd.octet   = w_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (tok_kind_ff == KIND_LITERAL) begin
               if (stat.free_now) begin
                  cmd.solo     = 1'b1;
                  cmd.solo_lit = 1'b1;
                  cmd.octet    = tok_lit_ff;
                  state_in     = ST_IDLE;
               end
            end else if (bad_dist) begin
               if (stat.free_now) begin
                  cmd.solo     = 1'b1;
                  cmd.solo_bad = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (len_sat == '0) begin
               if (stat.free_now) begin
                  cmd.solo = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               rd_ptr_in   = AW'(start_p);
               iss_left_in = len_sat;
               iss_cnt_in  = '0;
               state_in    = ST_COPY;
            end
         end
         ST_COPY: begin
            if (issue) begin
               rd_ptr_in   = (rd_ptr_ff == WP_LAST) ? '0 : rd_ptr_ff + AW'(1);
               iss_left_in = iss_left_ff - LW'(1);
               iss_cnt_in  = completes ? '0 : iss_cnt_ff + OCT_IDX_W'(1);
            end
            if (w_vld_ff) begin
               cmd.push  = 1'b1;
               cmd.flush = w_flush_ff;
               cmd.last  = w_last_ff;
               if (w_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         fill_ff  <= '0;
         w_vld_ff <= 1'b0;
         fwd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         w_vld_ff <= issue;
         fwd_ff   <= issue && fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tok_kind_ff <= req_bus.kind;
         tok_lit_ff  <= req_bus.literal_byte;
         tok_len_ff  <= req_bus.match_length;
         tok_dist_ff <= req_bus.match_distance;
      end
      rd_ptr_ff   <= rd_ptr_in;
      iss_left_ff <= iss_left_in;
      iss_cnt_ff  <= iss_cnt_in;
      w_flush_ff  <= w_flush_in;
      w_last_ff   <= w_last_in;
      fwd_data_ff <= w_byte;
   end

   lzwd_hist_ram #(
      .DEPTH (WINDOW_SIZE)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   lzwd_packer u_packer (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (stat),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// LZ77 window decoder testbench
// Sends literal and match tokens into the decoder and checks every result
// word against a self-contained model that keeps its own copy of the
// history window. The run covers directed corner tokens, random token
// streams, a long fill that wraps the window, and random handshake stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lzwd_pkg::*;

   localparam int WINDOW      = 32768;
   localparam int MAX_COPY    = 258;
   localparam int WORD_OCTS   = 8;
   localparam int PTR_W       = 15;
   localparam int CLK_PERIOD  = 10;
   localparam int LATENCY_PAD = 16;

   typedef struct packed {
      logic [DATA_W-1:0] data_bytes;
      logic [CNT_W-1:0]  byte_count;
      logic              last;
      logic              bad_distance;
   } out_word_type;

   // Decodes each accepted token into the words the block must produce and
   // checks arriving words in order.
   class lz_window_scoreboard;
      octet_type        history [WINDOW];
      logic [PTR_W-1:0] write_ptr = '0;
      int unsigned      filled = 0;
      out_word_type     pending_words[$];
      int unsigned      mismatches = 0;
      int unsigned      words_checked = 0;
      int unsigned      literals = 0;
      int unsigned      copies = 0;
      int unsigned      empty_copies = 0;
      int unsigned      clipped = 0;
      int unsigned      bad_tokens = 0;
      int unsigned      bytes_out = 0;

      function void push_octet(octet_type b);
         history[write_ptr] = b;
         write_ptr++;
         if (filled < WINDOW) begin
            filled++;
         end
         bytes_out++;
      endfunction

      function void take_token(logic [KIND_W-1:0] kind, octet_type lit,
                               logic [LEN_W-1:0] len, logic [DIST_W-1:0] distance);
         out_word_type     w;
         int unsigned      n;
         logic [PTR_W-1:0] src;
         w = '0;
         w.last = 1'b1;
         if (kind == KIND_LITERAL) begin
            push_octet(lit);
            w.data_bytes[7:0] = lit;
            w.byte_count = CNT_W'(1);
            pending_words.push_back(w);
            literals++;
            return;
         end
         // The distance check wins over the zero-length case.
         if (distance == 0 || distance > filled) begin
            w.bad_distance = 1'b1;
            pending_words.push_back(w);
            bad_tokens++;
            return;
         end
         n = (len > MAX_COPY) ? MAX_COPY : len;
         if (len > MAX_COPY) begin
            clipped++;
         end
         if (n == 0) begin
            pending_words.push_back(w);
            empty_copies++;
            return;
         end
         copies++;
         w = '0;
         // Bytes are read back one at a time so that overlapping copies
         // repeat with the period of the distance.
         for (int unsigned done = 0; done < n; done++) begin
            src = write_ptr - distance[PTR_W-1:0];
            w.data_bytes[8*w.byte_count +: 8] = history[src];
            push_octet(history[src]);
            w.byte_count++;
            if (w.byte_count == WORD_OCTS || done == n - 1) begin
               w.last = (done == n - 1);
               pending_words.push_back(w);
               w = '0;
            end
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) begin
            $display("tb: mismatch at %0t ns: %s", $time, msg);
         end
      endtask

      task check_word(out_word_type got);
         out_word_type want;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word data %h count %0d last %0b bad %0b",
                             got.data_bytes, got.byte_count, got.last, got.bad_distance));
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         if (got.data_bytes !== want.data_bytes) begin
            report($sformatf("word %0d data_bytes %h, want %h",
                             words_checked, got.data_bytes, want.data_bytes));
         end
         if (got.byte_count !== want.byte_count) begin
            report($sformatf("word %0d byte_count %0d, want %0d",
                             words_checked, got.byte_count, want.byte_count));
         end
         if (got.last !== want.last) begin
            report($sformatf("word %0d last %0b, want %0b",
                             words_checked, got.last, want.last));
         end
         if (got.bad_distance !== want.bad_distance) begin
            report($sformatf("word %0d bad_distance %0b, want %0b",
                             words_checked, got.bad_distance, want.bad_distance));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzwd_req_if req_bus ();
   lzwd_rsp_if rsp_bus ();

   lz77_window_decoder_unit #(
      .WINDOW_SIZE (WINDOW),
      .MAX_MATCH   (MAX_COPY),
      .OUT_BYTES   (WORD_OCTS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   lz_window_scoreboard sb = new;

   int unsigned rsp_hold_cycles = 0;
   bit          tx_back_to_back = 1'b0;
   int unsigned tx_calm = 0;
   int unsigned rx_calm = 0;
   int unsigned tokens_sent = 0;

   // Idle draw per token or result word; now and then a run goes through with no gaps.
   function automatic int unsigned draw_idle(ref int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [DIST_W-1:0] good_distance(int unsigned span);
      int unsigned lim;
      lim = (sb.filled < span) ? sb.filled : span;
      if (lim == 0) begin
         return DIST_W'(1);
      end
      if ($urandom_range(0, 1) == 0 && lim > 16) begin
         lim = 16;
      end
      return DIST_W'($urandom_range(1, lim));
   endfunction

   task automatic send_token(logic [KIND_W-1:0] kind, octet_type lit,
                             logic [LEN_W-1:0] len, logic [DIST_W-1:0] distance);
      int unsigned gap;
      gap = tx_back_to_back ? 0 : draw_idle(tx_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.kind           <= kind;
      req_bus.literal_byte   <= lit;
      req_bus.match_length   <= len;
      req_bus.match_distance <= distance;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_token(kind, lit, len, distance);
      tokens_sent++;
   endtask

   task automatic send_random(int unsigned dist_span, int unsigned long_pct);
      int unsigned       roll;
      logic [LEN_W-1:0]  len;
      roll = $urandom_range(0, 99);
      len  = LEN_W'($urandom_range(0, 24));
      if ($urandom_range(0, 99) < long_pct) begin
         len = LEN_W'($urandom_range(25, MAX_COPY));
      end
      if ($urandom_range(0, 19) == 0) begin
         len = LEN_W'($urandom_range(MAX_COPY + 1, 511));
      end
      if (roll < 30) begin
         send_token(KIND_LITERAL, octet_type'($urandom), LEN_W'($urandom),
                    DIST_W'($urandom));
      end else if (roll < 88) begin
         send_token(KIND_MATCH, octet_type'($urandom), len, good_distance(dist_span));
      end else if (roll < 92) begin
         send_token(KIND_MATCH, octet_type'($urandom), len, '0);
      end else begin
         send_token(KIND_MATCH, octet_type'($urandom), len,
                    DIST_W'($urandom_range(sb.filled + 1, 65535)));
      end
   endtask

   // Holds the token side idle until every expected word has come back.
   task automatic drain;
      req_bus.valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   initial begin : rsp_side
      int unsigned  stall;
      out_word_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = draw_idle(rx_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.data_bytes   = rsp_bus.data_bytes;
         got.byte_count   = rsp_bus.byte_count;
         got.last         = rsp_bus.last;
         got.bad_distance = rsp_bus.bad_distance;
         sb.check_word(got);
      end
   end

   initial begin : req_side
      req_bus.valid          <= 1'b0;
      req_bus.kind           <= KIND_LITERAL;
      req_bus.literal_byte   <= '0;
      req_bus.match_length   <= '0;
      req_bus.match_distance <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Corner tokens, starting from an empty history.
      send_token(KIND_MATCH,   8'h00, 9'd4,   16'd1);
      send_token(KIND_LITERAL, 8'h00, 9'd511, 16'hffff);
      send_token(KIND_LITERAL, 8'hff, 9'd0,   16'd0);
      send_token(KIND_LITERAL, 8'ha5, 9'd3,   16'd1);
      send_token(KIND_LITERAL, 8'h5a, 9'd7,   16'd2);
      send_token(KIND_MATCH,   8'h00, 9'd0,   16'd1);
      send_token(KIND_MATCH,   8'h00, 9'd0,   16'd0);
      send_token(KIND_MATCH,   8'hff, 9'd1,   16'd1);
      send_token(KIND_MATCH,   8'h00, 9'd8,   16'd2);
      send_token(KIND_MATCH,   8'h00, 9'd9,   16'd3);
      send_token(KIND_MATCH,   8'h00, 9'd16,  16'd16);
      send_token(KIND_MATCH,   8'h00, 9'd258, 16'd5);
      send_token(KIND_MATCH,   8'h00, 9'd511, 16'd7);
      send_token(KIND_MATCH,   8'h00, 9'd259, DIST_W'(sb.filled));
      send_token(KIND_MATCH,   8'h00, 9'd3,   DIST_W'(sb.filled + 1));
      send_token(KIND_MATCH,   8'h00, 9'd10,  16'hffff);
      send_token(KIND_MATCH,   8'h00, 9'd10,  16'h8000);
      send_token(KIND_MATCH,   8'h00, 9'd2,   16'd1);
      send_token(KIND_LITERAL, 8'h3c, 9'd0,   16'd0);
      drain;

      repeat (10) send_random(WINDOW, 15);
      drain;

      // The result side stops for a long stretch while tokens keep coming.
      rsp_hold_cycles = 400;
      tx_back_to_back = 1'b1;
      repeat (12) begin
         send_token(KIND_MATCH, octet_type'($urandom), LEN_W'($urandom_range(17, 40)),
                    good_distance(WINDOW));
      end
      tx_back_to_back = 1'b0;
      drain;

      // Long copies until the window has wrapped and filled completely.
      while (sb.bytes_out < WINDOW + 256) begin
         send_token(KIND_MATCH, octet_type'($urandom),
                    LEN_W'($urandom_range(240, 511)), good_distance(WINDOW));
      end
      drain;

      // With a full window the farthest distance is legal, one more is not.
      send_token(KIND_MATCH,   8'h00, 9'd258, 16'h8000);
      send_token(KIND_MATCH,   8'h00, 9'd300, 16'h7fff);
      send_token(KIND_MATCH,   8'h00, 9'd5,   16'h8001);
      send_token(KIND_MATCH,   8'h00, 9'd0,   16'h8000);
      send_token(KIND_LITERAL, 8'h81, 9'd0,   16'd0);

      repeat (5) send_random(WINDOW, 25);
      drain;

      $display("tb: %0d tokens: %0d literals, %0d copies, %0d empty copies,",
               tokens_sent, sb.literals, sb.copies, sb.empty_copies);
      $display("tb: %0d clipped lengths, %0d bad distances, %0d result words checked,",
               sb.clipped, sb.bad_tokens, sb.words_checked);
      $display("tb: %0d bytes decoded, window wrapped %0d times",
               sb.bytes_out, sb.bytes_out / WINDOW);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
